// ----- rtl/lapf_pkg.sv -----
// Shared types and constants of the Laplacian 3x3 edge filter.
package lapf_pkg;

   localparam int PIXEL_W      = 8;
   localparam int EDGE_W       = 11;
   localparam int CENTRE_COL_W = 10;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;
   localparam int CSR_DATA_W   = 12;
   localparam int CSR_INDEX_W  = 1;
   localparam int DIM_W        = 13;

   localparam logic [DIM_W-1:0] MIN_DIM = 13'd5;
   localparam logic [DIM_W-1:0] BORDER  = 13'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic [PIXEL_W-1:0] upper;
      logic [PIXEL_W-1:0] middle;
      logic [PIXEL_W-1:0] lower;
   } column_type;

endpackage

// ----- rtl/laplacian_3x3_edge_filter.sv -----
// Top level of the streaming 3x3 four-neighbour Laplacian edge filter.
// Takes one pixel per clock in raster order while the output is not stalled and
// gives one result per clock at most; a result passes through the registered
// line-store read, the window shift and the kernel sum into the output register,
// in that order, after the pixel that completes its window. The two line stores share one
// RAM of MAX_WIDTH entries, read and written once per pixel at its column; the
// window is a row of three column cells. Centres in the two-pixel border of
// the frame give no result. A register write restarts the frame counters.
module laplacian_3x3_edge_filter #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lapf_pkg::PIXEL_W-1:0]          req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lapf_pkg::EDGE_W-1:0]    rsp_edge_value,
   output logic [lapf_pkg::CENTRE_COL_W-1:0]     rsp_centre_column,
   output logic [lapf_pkg::ROW_W-1:0]            rsp_centre_row,
   output logic                                  rsp_frame_last,
   input  logic                                  csr_write_enable,
   input  logic [lapf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lapf_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int DW    = lapf_pkg::DIM_W;
   localparam int PW    = lapf_pkg::PIXEL_W;
   localparam int EW    = lapf_pkg::EDGE_W;
   localparam logic [DW-1:0] MaxWidthDim = DW'(MAX_WIDTH);

   logic [lapf_pkg::WIDTH_REG_W-1:0]  image_width_ff;
   logic [lapf_pkg::HEIGHT_REG_W-1:0] image_height_ff;
   logic [COL_W-1:0]                  column_count_ff, column_count_in;
   logic [lapf_pkg::ROW_W-1:0]        row_count_ff, row_count_in;
   logic [DW-1:0]                     eff_width, eff_height, col_ext, row_ext;

   logic advance, accept, emit_now, last_now, shift_window;

   logic                                s1_valid_ff;
   logic [PW-1:0]                       s1_pixel_ff;
   logic [COL_W-1:0]                    s1_column_ff;
   logic                                s1_emit_ff, s1_last_ff;
   logic [lapf_pkg::CENTRE_COL_W-1:0]   s1_centre_column_ff;
   logic [lapf_pkg::ROW_W-1:0]          s1_centre_row_ff;

   logic                                s2_valid_ff;
   logic                                s2_emit_ff, s2_last_ff;
   logic [lapf_pkg::CENTRE_COL_W-1:0]   s2_centre_column_ff;
   logic [lapf_pkg::ROW_W-1:0]          s2_centre_row_ff;

   logic                                rsp_valid_ff;
   logic [EW-1:0]                       edge_value_ff;
   logic [lapf_pkg::CENTRE_COL_W-1:0]   centre_column_ff;
   logic [lapf_pkg::ROW_W-1:0]          centre_row_ff;
   logic                                frame_last_ff;

   logic [2*PW-1:0] ram_read_data, ram_write_data;
   logic [PW-1:0]   read_upper, read_middle;
   logic [EW-1:0]   edge_sum;

   lapf_pkg::column_type chain [4];

   always_comb begin
      eff_width = DW'(image_width_ff);
      if (eff_width < lapf_pkg::MIN_DIM) begin
         eff_width = lapf_pkg::MIN_DIM;
      end else if (eff_width > MaxWidthDim) begin
         eff_width = MaxWidthDim;
      end
      eff_height = DW'(image_height_ff);
      if (eff_height < lapf_pkg::MIN_DIM) begin
         eff_height = lapf_pkg::MIN_DIM;
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign col_ext = DW'(column_count_ff);
   assign row_ext = DW'(row_count_ff);

   assign emit_now = (col_ext >= lapf_pkg::BORDER + 13'd1)
                  && (col_ext + lapf_pkg::BORDER <= eff_width)
                  && (row_ext >= lapf_pkg::BORDER + 13'd1)
                  && (row_ext + lapf_pkg::BORDER <= eff_height);
   assign last_now = (col_ext + lapf_pkg::BORDER == eff_width)
                  && (row_ext + lapf_pkg::BORDER == eff_height);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_write_enable) begin
         column_count_in = '0;
         row_count_in    = '0;
      end else if (accept) begin
         if (col_ext + 13'd1 >= eff_width) begin
            column_count_in = '0;
            row_count_in    = (row_ext + 13'd1 >= eff_height) ? '0 : row_count_ff + 12'd1;
         end else begin
            column_count_in = column_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= lapf_pkg::WIDTH_RESET;
         image_height_ff <= lapf_pkg::HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         if (csr_write_enable) begin
            case (csr_index)
               lapf_pkg::REG_IMAGE_WIDTH: begin
                  image_width_ff <= csr_write_data[lapf_pkg::WIDTH_REG_W-1:0];
               end
               lapf_pkg::REG_IMAGE_HEIGHT: begin
                  image_height_ff <= csr_write_data[lapf_pkg::HEIGHT_REG_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // stage 1: pixel waits for its line-store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff         <= req_pixel;
         s1_column_ff        <= column_count_ff;
         s1_emit_ff          <= emit_now;
         s1_last_ff          <= last_now;
         s1_centre_column_ff <= lapf_pkg::CENTRE_COL_W'(col_ext - 13'd1);
         s1_centre_row_ff    <= row_count_ff - 12'd1;
      end
   end

   assign read_upper     = ram_read_data[2*PW-1:PW];
   assign read_middle    = ram_read_data[PW-1:0];
   assign shift_window   = advance && s1_valid_ff;
   assign ram_write_data = {read_middle, s1_pixel_ff};

   lapf_ram #(
      .WIDTH (2*PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock         (clock),
      .write_enable  (shift_window),
      .write_address (s1_column_ff),
      .write_data    (ram_write_data),
      .read_enable   (accept),
      .read_address  (column_count_ff),
      .read_data     (ram_read_data)
   );

   // window: cell 0 newest column, cell 1 centre, cell 2 oldest
   assign chain[0] = '{upper: read_upper, middle: read_middle, lower: s1_pixel_ff};

   for (genvar k = 0; k < 3; k++) begin : g_cell
      lapf_cell u_cell (
         .clock        (clock),
         .shift_enable (shift_window),
         .column_in    (chain[k]),
         .column_out   (chain[k+1])
      );
   end

   // stage 2: window holds the item's neighbourhood
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_window) begin
         s2_emit_ff          <= s1_emit_ff;
         s2_last_ff          <= s1_last_ff;
         s2_centre_column_ff <= s1_centre_column_ff;
         s2_centre_row_ff    <= s1_centre_row_ff;
      end
   end

   assign edge_sum = EW'(chain[2].upper) + EW'(chain[3].middle)
                   + EW'(chain[1].middle) + EW'(chain[2].lower)
                   - {1'b0, chain[2].middle, 2'b00};

   // stage 3: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         edge_value_ff    <= edge_sum;
         centre_column_ff <= s2_centre_column_ff;
         centre_row_ff    <= s2_centre_row_ff;
         frame_last_ff    <= s2_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_edge_value    = $signed(edge_value_ff);
   assign rsp_centre_column = centre_column_ff;
   assign rsp_centre_row    = centre_row_ff;
   assign rsp_frame_last    = frame_last_ff;

endmodule

// ----- rtl/lapf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lapf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- rtl/lapf_cell.sv -----
// One column cell of the 3x3 window: holds three pixels and hands them on.
module lapf_cell (
   input  logic                  clock,
   input  logic                  shift_enable,
   input  lapf_pkg::column_type  column_in,
   output lapf_pkg::column_type  column_out
);

   lapf_pkg::column_type column_ff;

   always_ff @(posedge clock) begin
      if (shift_enable) begin
         column_ff <= column_in;
      end
   end

   assign column_out = column_ff;

endmodule

// ----- sim/lapf_checker.sv -----
// Scoreboard for the Laplacian edge filter: predicts every result from the pixel stream.
`timescale 1ns / 100ps

module lapf_checker
   import lapf_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [PIXEL_W-1:0]             req_pixel,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [EDGE_W-1:0]       rsp_edge_value,
   input  logic [CENTRE_COL_W-1:0]        rsp_centre_column,
   input  logic [ROW_W-1:0]               rsp_centre_row,
   input  logic                           rsp_frame_last,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_write_data,
   output int                             error_count,
   output int                             checked_count,
   output int                             pending_count
);

   typedef struct {
      logic [EDGE_W-1:0]       edge_value;
      logic [CENTRE_COL_W-1:0] centre_column;
      logic [ROW_W-1:0]        centre_row;
      logic                    frame_last;
   } edge_result_type;

   edge_result_type         pending_edges[$];
   logic [PIXEL_W-1:0]      two_rows_up[MAX_WIDTH];
   logic [PIXEL_W-1:0]      one_row_up[MAX_WIDTH];
   logic [PIXEL_W-1:0]      tap[3][3];
   logic [WIDTH_REG_W-1:0]  width_setting;
   logic [HEIGHT_REG_W-1:0] height_setting;
   int unsigned             next_col;
   int unsigned             next_row;

   function automatic void check_field(string field, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   function automatic void predict_laplacian(logic [PIXEL_W-1:0] pixel);
      int unsigned     eff_w;
      int unsigned     eff_h;
      int unsigned     col;
      int unsigned     row;
      int              sum;
      edge_result_type result;
      eff_w = (width_setting < WIDTH_REG_W'(MIN_DIM)) ? int'(MIN_DIM) : int'(width_setting);
      if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
      eff_h = (height_setting < HEIGHT_REG_W'(MIN_DIM)) ? int'(MIN_DIM)
                                                        : int'(height_setting);
      col = (next_col >= MAX_WIDTH) ? 0 : next_col;
      row = next_row;
      for (int i = 0; i < 3; i++) begin
         tap[i][0] = tap[i][1];
         tap[i][1] = tap[i][2];
      end
      tap[0][2] = two_rows_up[col];
      tap[1][2] = one_row_up[col];
      tap[2][2] = pixel;
      two_rows_up[col] = tap[1][2];
      one_row_up[col]  = pixel;
      if (col >= BORDER + 1 && col + BORDER <= eff_w &&
          row >= BORDER + 1 && row + BORDER <= eff_h) begin
         sum = int'(tap[0][1]) + int'(tap[1][0]) + int'(tap[1][2]) + int'(tap[2][1])
               - 4 * int'(tap[1][1]);
         result.edge_value    = sum[EDGE_W-1:0];
         result.centre_column = CENTRE_COL_W'(col - 1);
         result.centre_row    = ROW_W'(row - 1);
         result.frame_last    = (col + BORDER == eff_w) && (row + BORDER == eff_h);
         pending_edges.push_back(result);
      end
      if (col + 1 >= eff_w) begin
         next_col = 0;
         next_row = (row + 1 >= eff_h) ? 0 : row + 1;
      end else begin
         next_col = col + 1;
         next_row = row;
      end
   endfunction

   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         width_setting  = WIDTH_RESET;
         height_setting = HEIGHT_RESET;
         next_col       = 0;
         next_row       = 0;
         error_count    = 0;
         checked_count  = 0;
         foreach (two_rows_up[i]) begin
            two_rows_up[i] = '0;
            one_row_up[i]  = '0;
         end
         foreach (tap[i, j]) tap[i][j] = '0;
         pending_edges.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_IMAGE_WIDTH) width_setting = csr_write_data[WIDTH_REG_W-1:0];
            if (csr_index == REG_IMAGE_HEIGHT) height_setting = csr_write_data;
            next_col = 0;
            next_row = 0;
         end
         if (req_valid && !req_stall) predict_laplacian(req_pixel);
         if (rsp_valid && !rsp_stall) begin
            if (pending_edges.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual edge %0d col %0d row %0d",
                        $time, rsp_edge_value, rsp_centre_column, rsp_centre_row);
            end else begin
               checked_count++;
               want = pending_edges.pop_front();
               check_field("edge_value", 32'($signed(want.edge_value)), 32'(rsp_edge_value));
               check_field("centre_column", 32'(want.centre_column), 32'(rsp_centre_column));
               check_field("centre_row", 32'(want.centre_row), 32'(rsp_centre_row));
               check_field("frame_last", 32'(want.frame_last), 32'(rsp_frame_last));
            end
         end
      end
      pending_count <= pending_edges.size();
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the Laplacian edge filter: drives pixels, register writes and stalls.
`timescale 1ns / 100ps

module tb;
   import lapf_pkg::*;

   localparam int                 SETTLE_CYCLES  = 8;
   localparam int                 CYCLE_LIMIT    = 600000;
   localparam int                 DEFAULT_PIXELS = 48;
   localparam int                 WIDE_PIXELS    = 48;
   localparam int                 TALL_PIXELS    = 200;
   localparam int                 RANDOM_PIXELS  = 480;
   localparam logic [PIXEL_W-1:0] PIXEL_MAX      = 8'hFF;

   logic                        clock             = 1'b0;
   logic                        reset             = 1'b1;
   logic                        req_valid         = 1'b0;
   logic                        req_stall;
   logic [PIXEL_W-1:0]          req_pixel         = '0;
   logic                        rsp_valid;
   logic                        rsp_stall         = 1'b0;
   logic signed [EDGE_W-1:0]    rsp_edge_value;
   logic [CENTRE_COL_W-1:0]     rsp_centre_column;
   logic [ROW_W-1:0]            rsp_centre_row;
   logic                        rsp_frame_last;
   logic                        csr_write_enable  = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index         = '0;
   logic [CSR_DATA_W-1:0]       csr_write_data    = '0;

   int error_count;
   int checked_count;
   int pending_count;
   int cycle_count        = 0;
   int pixel_total        = 0;
   int settings_written   = 0;
   int sender_idle_pct    = 7;
   int receiver_idle_pct  = 75;

   laplacian_3x3_edge_filter i_dut (.*);

   lapf_checker i_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < receiver_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return PIXEL_MAX;
         default: return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixel_total++;
   endtask

   // hold off until every predicted result has been seen, then let the pipeline empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input bit set_width, input bit set_height,
                            input logic [WIDTH_REG_W-1:0] width,
                            input logic [HEIGHT_REG_W-1:0] height);
      drain_results();
      if (set_width) begin
         csr_write_enable <= 1'b1;
         csr_index        <= REG_IMAGE_WIDTH;
         csr_write_data   <= CSR_DATA_W'(width);
         @(posedge clock);
      end
      if (set_height) begin
         csr_write_enable <= 1'b1;
         csr_index        <= REG_IMAGE_HEIGHT;
         csr_write_data   <= height;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      settings_written++;
   endtask

   initial begin
      int random_pixels;
      int burst;
      int kind;
      random_pixels = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      repeat (DEFAULT_PIXELS) send_pixel(random_pixel());

      configure(1'b1, 1'b1, 11'd4, 12'd6);
      for (int r = 0; r < 6; r++) begin
         for (int c = 0; c < 5; c++) begin
            send_pixel((((r == 2 || r == 4) && c == 2) || (r == 3 && (c == 1 || c == 3)))
                       ? PIXEL_MAX : '0);
         end
      end

      configure(1'b1, 1'b1, 11'd2047, 12'd0);
      repeat (WIDE_PIXELS) send_pixel(random_pixel());

      sender_idle_pct   = 75;
      receiver_idle_pct <= 7;
      configure(1'b1, 1'b1, 11'd5, 12'd4095);
      repeat (TALL_PIXELS) send_pixel(random_pixel());

      while (random_pixels < RANDOM_PIXELS) begin
         if (random_pixels >= RANDOM_PIXELS / 2) begin
            sender_idle_pct   = 0;
            receiver_idle_pct <= 0;
         end
         kind = $urandom_range(3);
         configure(kind != 1, kind != 0, WIDTH_REG_W'($urandom_range(15)),
                   ($urandom_range(9) == 0) ? 12'd4095 : HEIGHT_REG_W'($urandom_range(15)));
         burst = $urandom_range(20, 160);
         repeat (burst) begin
            if ($urandom_range(99) == 0) drain_results();
            send_pixel(random_pixel());
         end
         random_pixels += burst;
      end

      drain_results();
      $display("Sent %0d pixels under %0d register settings, %0d results checked.",
               pixel_total, settings_written, checked_count);
      $display("Covered reset geometry, clamped sizes, a 4095-row height and small random frames.");
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
